// ===== rtl/core/dot_pkg.sv =====
// ----------------------------------------------------------------------------
// dot_pkg: shared types and constants of the detector occupancy tracker
// Entry layout, configuration bundle, opcodes, register indexes, sequencer
// states and the small arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dot_pkg;

   localparam int DETECTORS  = 32;
   localparam int WINDOW     = 10;
   localparam int ADDR_W     = $clog2(DETECTORS);
   localparam int SUM_W      = $clog2(WINDOW + 1);
   localparam int CNT_W      = 16;
   localparam int LEVEL_W    = 15;
   localparam int FRAC_W     = 8;
   localparam int PCT_W      = 7;
   localparam int SHIFT_W    = 3;
   localparam int MASK_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0]   CNT_MAX       = {CNT_W{1'b1}};
   localparam logic [PCT_W-1:0]   PCT_FULL      = 7'd100;
   localparam logic [LEVEL_W:0]   ROUND_HALF    = 16'd128;
   localparam logic [MASK_W-1:0]  PRESENT_RESET = 32'hFFFF_FFFF;
   localparam logic [MASK_W-1:0]  FAULT_RESET   = 32'h0000_0000;
   localparam logic [SHIFT_W-1:0] RISE_RESET    = 3'd1;
   localparam logic [SHIFT_W-1:0] FALL_RESET    = 3'd3;
   localparam logic [CNT_W-1:0]   HOLD_RESET    = 16'd600;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_RISE     = 3'd1,
      OP_FALL     = 3'd2,
      OP_READ     = 3'd3,
      OP_CLR_RISE = 3'd4,
      OP_CLR_FALL = 3'd5
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PRESENT = 3'd0,
      CSR_FAULT   = 3'd1,
      CSR_RISE    = 3'd2,
      CSR_FALL    = 3'd3,
      CSR_HOLD    = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ISSUE = 2'd1,
      ST_DRAIN = 2'd2,
      ST_DONE  = 2'd3
   } state_type;

   typedef struct packed {
      logic [MASK_W-1:0]  present;
      logic [MASK_W-1:0]  fault;
      logic [SHIFT_W-1:0] rise_shift;
      logic [SHIFT_W-1:0] fall_shift;
      logic [CNT_W-1:0]   hold_timeout;
   } cfg_type;

   typedef struct packed {
      logic               occupied;
      logic [CNT_W-1:0]   rise_ticks;
      logic [CNT_W-1:0]   fall_ticks;
      logic [CNT_W-1:0]   rise_count;
      logic [CNT_W-1:0]   fall_count;
      logic [WINDOW-1:0]  window;
      logic [LEVEL_W-1:0] level;
   } entry_type;

   typedef logic [PCT_W-1:0] pct_lut_type [WINDOW+1];

   // Percent for every possible window sum, settled at elaboration.
   function automatic pct_lut_type build_pct_lut();
      pct_lut_type lut;
      for (int i = 0; i <= WINDOW; i++) begin
         lut[i] = PCT_W'((i * 100) / WINDOW);
      end
      return lut;
   endfunction

   localparam pct_lut_type PCT_LUT = build_pct_lut();

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [PCT_W-1:0] win_percent(input logic [WINDOW-1:0] w);
      logic [SUM_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < WINDOW; i++) begin
         sum = sum + SUM_W'(w[i]);
      end
      return PCT_LUT[sum];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dot_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dot_cfg_regs: configuration register bank
// Write-only registers loaded from the plain write port; unknown indexes are
// ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module dot_cfg_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dot_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dot_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dot_pkg::cfg_type                cfg
);
   import dot_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_PRESENT: cfg_in.present      = csr_wdata[MASK_W-1:0];
            CSR_FAULT:   cfg_in.fault        = csr_wdata[MASK_W-1:0];
            CSR_RISE:    cfg_in.rise_shift   = csr_wdata[SHIFT_W-1:0];
            CSR_FALL:    cfg_in.fall_shift   = csr_wdata[SHIFT_W-1:0];
            CSR_HOLD:    cfg_in.hold_timeout = csr_wdata[CNT_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.present      <= PRESENT_RESET;
         cfg_ff.fault        <= FAULT_RESET;
         cfg_ff.rise_shift   <= RISE_RESET;
         cfg_ff.fall_shift   <= FALL_RESET;
         cfg_ff.hold_timeout <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dot_entry_mem.sv =====
// ----------------------------------------------------------------------------
// dot_entry_mem: per-detector state memory
// One write port and one registered read port. A valid bit per entry, cleared
// by reset, makes an entry that was never written read as all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dot_entry_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [dot_pkg::ADDR_W-1:0]  rd_addr,
   output dot_pkg::entry_type          rd_data,
   input  logic                        wr_en,
   input  logic [dot_pkg::ADDR_W-1:0]  wr_addr,
   input  dot_pkg::entry_type          wr_data
);
   import dot_pkg::*;

   entry_type              mem_ff [DETECTORS];
   logic [DETECTORS-1:0]   vld_ff;
   entry_type              rd_data_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

`ifndef SYNTH
   // The sequencer never reads the entry it is writing back.
   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> rd_addr != wr_addr)
      else $error("read and write of the same entry in one cycle");

   a_written_is_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[$past(wr_addr)])
      else $error("written entry not marked valid");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dot_entry_calc.sv =====
// ----------------------------------------------------------------------------
// dot_entry_calc: read-modify-write update of one detector entry
// Applies an edge, a clear or one tick step (counters, window, smoothed
// level and the hold timeout check) to the entry read from memory.
// ----------------------------------------------------------------------------
`default_nettype none

module dot_entry_calc (
   input  dot_pkg::op_type    op,
   input  dot_pkg::cfg_type   cfg,
   input  logic               present,
   input  logic               fault,
   input  dot_pkg::entry_type cur,
   output dot_pkg::entry_type upd
);
   import dot_pkg::*;

   logic [WINDOW:0]      shifted;
   logic [PCT_W-1:0]     pct;
   logic [LEVEL_W-1:0]   target;
   logic [LEVEL_W-1:0]   diff_up;
   logic [LEVEL_W-1:0]   diff_dn;
   entry_type            ent;

   always_comb begin
      ent     = cur;
      shifted = {cur.window, cur.occupied};
      pct     = win_percent(shifted[WINDOW-1:0]);
      target  = {pct, {FRAC_W{1'b0}}};
      diff_up = target - cur.level;
      diff_dn = cur.level - target;
      case (op)
         OP_TICK: begin
            if (present && !fault) begin
               ent.rise_ticks = sat_inc(cur.rise_ticks);
               if (!cur.occupied) begin
                  ent.fall_ticks = sat_inc(cur.fall_ticks);
               end
               ent.window = shifted[WINDOW-1:0];
               if (target > cur.level) begin
                  ent.level = cur.level + (diff_up >> cfg.rise_shift);
               end else begin
                  ent.level = cur.level - (diff_dn >> cfg.fall_shift);
               end
            end
            // The hold timeout applies to faulty detectors as well.
            if (present && ent.occupied && (ent.rise_ticks > cfg.hold_timeout)) begin
               ent.fall_count = sat_inc(cur.fall_count);
               ent.occupied   = 1'b0;
               ent.fall_ticks = '0;
            end
         end
         OP_RISE: begin
            ent.rise_count = sat_inc(cur.rise_count);
            ent.occupied   = 1'b1;
            ent.fall_ticks = '0;
            ent.rise_ticks = '0;
         end
         OP_FALL: begin
            ent.fall_count = sat_inc(cur.fall_count);
            ent.occupied   = 1'b0;
            ent.fall_ticks = '0;
         end
         OP_CLR_RISE: ent.rise_count = '0;
         OP_CLR_FALL: ent.fall_count = '0;
         default:     ent = cur;
      endcase
   end

   assign upd = ent;

endmodule

`default_nettype wire

// ===== rtl/core/detector_occupancy_tracker.sv =====
// ----------------------------------------------------------------------------
// detector_occupancy_tracker: occupancy tracking for a bank of detectors
// Sequencer that walks the per-detector state memory, updates entries and
// returns one result per transaction for the addressed detector.
// ----------------------------------------------------------------------------
// Sequence: an accepted request reads its entry in ISSUE (a tick walks every
// entry, one read per entry), writes the last entry back in DRAIN and loads
// the result in DONE. One transaction at a time; a result not yet taken
// holds the following one in DONE. Reset: synchronous; control registers
// and configuration return to their reset values and all detector entries
// read as zero at once through per-entry valid bits.
`default_nettype none

module detector_occupancy_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // det_index [4:0], zero fill [7:5]
   input  logic [7:0]                      req_tdata,
   // opcode [2:0]
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // det_occupied [0], ticks_since_rise [16:1], ticks_since_fall [32:17],
   // rising_count [48:33], falling_count [64:49], occupancy_now [71:65],
   // occupancy_smoothed [78:72], is_faulty [79], is_present [80], zero [87:81]
   output logic [87:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [dot_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dot_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dot_pkg::*;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic                stage_vld_ff;
   logic [ADDR_W-1:0]   stage_addr_ff;
   entry_type           hold_ff, hold_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [87:0]         rsp_data_ff, rsp_data_in;

   cfg_type             cfg;
   entry_type           rd_data;
   entry_type           upd;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                last_issue;
   logic                rsp_free;
   logic                load_rsp;
   logic                accept;
   logic [LEVEL_W:0]    rounded;
   logic [PCT_W-1:0]    smooth_pct;

   dot_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dot_entry_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (stage_vld_ff),
      .wr_addr (stage_addr_ff),
      .wr_data (upd)
   );

   dot_entry_calc u_calc (
      .op      (op_ff),
      .cfg     (cfg),
      .present (cfg.present[stage_addr_ff]),
      .fault   (cfg.fault[stage_addr_ff]),
      .cur     (rd_data),
      .upd     (upd)
   );

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign last_issue = (op_ff != OP_TICK) || (cnt_ff == ADDR_W'(DETECTORS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_ISSUE;
         ST_ISSUE: if (last_issue) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_ISSUE: rd_en      = 1'b1;
         ST_DRAIN: rd_en      = 1'b0;
         ST_DONE:  load_rsp   = rsp_free;
         default:  req_tready = 1'b0;
      endcase
   end

   assign accept  = req_tvalid && req_tready;
   // A tick walks the whole bank; every other transaction touches one entry.
   assign rd_addr = (op_ff == OP_TICK) ? cnt_ff : idx_ff;

   assign rounded    = {1'b0, hold_ff.level} + ROUND_HALF;
   assign smooth_pct = (rounded[LEVEL_W:FRAC_W] > 8'(PCT_FULL)) ? PCT_FULL
                                                                : rounded[FRAC_W+PCT_W-1:FRAC_W];

   always_comb begin
      op_in        = op_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         op_in  = op_type'(req_tuser);
         idx_in = req_tdata[ADDR_W-1:0];
         cnt_in = '0;
      end
      if (rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (stage_vld_ff && (stage_addr_ff == idx_ff)) begin
         hold_in = upd;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'b0,
                         cfg.present[idx_ff],
                         cfg.fault[idx_ff],
                         smooth_pct,
                         win_percent(hold_ff.window),
                         hold_ff.fall_count,
                         hold_ff.rise_count,
                         hold_ff.fall_ticks,
                         hold_ff.rise_ticks,
                         hold_ff.occupied};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         stage_vld_ff <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      stage_addr_ff <= rd_addr;
      hold_ff       <= hold_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction accepted while one is in flight");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the done state");

   a_writeback_busy: assert property (@(posedge clock) disable iff (reset)
      stage_vld_ff |-> (state_ff == ST_ISSUE) || (state_ff == ST_DRAIN))
      else $error("entry written back while the sequencer is not walking");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending result changed before it was taken");
`endif

endmodule

`default_nettype wire
